/* design/bdpc_pkg.sv */
// bdpc_pkg: shared types and constants of the button debounce press classifier
// no dependencies; imported by every module of the block

package bdpc_pkg;

    // default number of buttons and field widths
    localparam int BUTTON_COUNT_DEF = 5;
    localparam int BUTTON_W         = 3;
    localparam int TDATA_IN_W       = 8;
    localparam int TDATA_OUT_W      = 8;
    localparam int TIME_W           = 32;
    localparam int CFG_W            = 16;
    localparam int CFG_IDX_W        = 1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

    // operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // press kinds
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // reports per tick and command queue depth (power of two)
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // one command as it travels from front to back
    typedef struct packed {
        logic                is_tick;
        logic [BUTTON_W-1:0] button;
        logic                level;
    } t_cmd;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* design/button_debounce_press_classifier_core.sv */
// button_debounce_press_classifier_core: top level of the press classifier
// depends on bdpc_pkg, bdpc_front, bdpc_queue and bdpc_back
//
// Usage:
//   s_axis carries one beat per event: tuser is the operation (edge or
//   one millisecond tick), tdata[2:0] the button and tdata[3] the level.
//   m_axis returns press reports: tdata[2:0] button, tuser long/short,
//   tlast marks the final report of one event.
//   The cfg channel writes the debounce time (index 0) and the long-press
//   threshold (index 1); always ready; user writes only while idle, not enforced.
// Timing:
//   The front takes a beat into a two-entry command queue.
//   An edge is dequeued in the idle state and evaluated in the edge
//   state, which loads its report into the output register.
//   A tick scans the buttons one per cycle in the scan state, then
//   emits one long report per cycle while the output is free, at most
//   five per tick, or goes back to idle when nothing reports.
// Reset and stall:
//   Reset clears the time counter, all button state and the queue, and
//   loads the configuration defaults. A stalled m_axis holds its report;
//   the back waits on the output register and the queue fills, after
//   which s_axis tready drops.

module button_debounce_press_classifier_core
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [2:0] button, [3] level, rest zero
    input  logic                   s_axis_tuser,   // [0] operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [2:0] button_id, rest zero
    output logic                   m_axis_tuser,   // [0] press_kind
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic                w_push;
    t_cmd                w_cmd;
    t_cmd                w_head;
    t_q_stat             w_q_stat;
    logic                w_pop;
    logic [BUTTON_W-1:0] w_button_id;

    assign o_cfg_ready = 1'b1;

    // decode and admit events
    bdpc_front #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_tdata  (s_axis_tdata[BUTTON_W:0]),
        .i_tuser  (s_axis_tuser),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_cmd)
    );

    // command queue
    bdpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // press state and reports
    bdpc_back #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head       (w_head),
        .i_q_stat     (w_q_stat),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_button_id  (w_button_id),
        .o_press_kind (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W-BUTTON_W){1'b0}}, w_button_id};

endmodule

/* design/bdpc_front.sv */
// bdpc_front: accepts input beats, decodes them into commands and drops
// edges on buttons that do not exist; depends on bdpc_pkg

module bdpc_front
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_tdata,   // [2:0] button, [3] level
    input  logic       i_tuser,   // operation
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic w_in_range;

    // accept whenever the queue has room
    assign o_ready = !i_q_stat.full;

    // classify the beat
    assign w_in_range = ({1'b0, i_tdata[BUTTON_W-1:0]} < (BUTTON_W+1)'(BUTTON_COUNT));

    always_comb begin
        o_cmd.is_tick = (i_tuser == OP_TICK);
        o_cmd.button  = i_tdata[BUTTON_W-1:0];
        o_cmd.level   = i_tdata[BUTTON_W];
    end

    // ticks always go on, edges only for existing buttons
    assign o_push = i_valid && o_ready && (o_cmd.is_tick || w_in_range);

endmodule

/* design/bdpc_queue.sv */
// bdpc_queue: short command queue between front and back
// depends on bdpc_pkg

module bdpc_queue
    import bdpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

/* design/bdpc_back.sv */
// bdpc_back: press state per button, tick scan and report output register
// depends on bdpc_pkg; takes commands from bdpc_queue

module bdpc_back
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  t_cmd                   i_head,
    input  t_q_stat                i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [BUTTON_W-1:0]    o_button_id,
    output logic                   o_press_kind,
    output logic                   o_last
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EDGE = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    t_cmd                    r_cmd;
    logic [CFG_W-1:0]        r_debounce;
    logic [CFG_W-1:0]        r_long_press;
    logic [TIME_W-1:0]       r_now;
    logic [TIME_W-1:0]       r_last_edge   [BUTTON_COUNT];
    logic [TIME_W-1:0]       r_press_start [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0] r_pressed;
    logic [BUTTON_COUNT-1:0] r_long_sent;
    logic [BUTTON_COUNT-1:0] r_mask;
    logic [IDX_W-1:0]        r_idx;
    logic [RES_CNT_W-1:0]    r_cnt;
    logic                    r_out_valid;
    logic [BUTTON_W-1:0]     r_out_id;
    logic                    r_out_kind;
    logic                    r_out_last;

    logic                    w_out_free;
    logic                    w_out_load;
    logic [IDX_W-1:0]        w_eb;
    logic [TIME_W-1:0]       w_since_edge;
    logic [TIME_W-1:0]       w_held_edge;
    logic                    w_edge_ok;
    logic                    w_edge_long;
    logic                    w_edge_report;
    logic [TIME_W-1:0]       w_held_scan;
    logic                    w_scan_hit;
    logic [IDX_W-1:0]        w_low;
    logic [BUTTON_COUNT-1:0] w_rem;
    logic                    w_emit_last;

    assign w_out_free = !r_out_valid || i_ready;

    // edge evaluation on the latched command
    assign w_eb          = r_cmd.button[IDX_W-1:0];
    assign w_since_edge  = r_now - r_last_edge[w_eb];
    assign w_held_edge   = r_now - r_press_start[w_eb];
    assign w_edge_ok     = (w_since_edge > {{(TIME_W-CFG_W){1'b0}}, r_debounce});
    assign w_edge_long   = (w_held_edge >= {{(TIME_W-CFG_W){1'b0}}, r_long_press});
    assign w_edge_report = w_edge_ok && !r_cmd.level && r_pressed[w_eb] && !r_long_sent[w_eb];

    // one button per cycle during the tick scan
    assign w_held_scan = r_now - r_press_start[r_idx];
    assign w_scan_hit  = r_pressed[r_idx] && !r_long_sent[r_idx] &&
                         (w_held_scan >= {{(TIME_W-CFG_W){1'b0}}, r_long_press});

    // lowest pending long report
    always_comb begin
        w_low = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            w_rem[i] = r_mask[i] && (w_low != IDX_W'(i));
        end
    end

    assign w_emit_last = (w_rem == '0) || (r_cnt == RES_CNT_W'(MAX_RESULTS - 1));

    // a new report enters the output register
    assign w_out_load = w_out_free &&
                        (((r_state == ST_EDGE) && w_edge_report) ||
                         ((r_state == ST_EMIT) && (r_mask != '0)));

    // sequencer
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = i_head.is_tick ? ST_SCAN : ST_EDGE;
                end
            end
            ST_EDGE: begin
                if (!w_edge_report || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_idx == IDX_W'(BUTTON_COUNT - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_mask == '0) begin
                    n_state = ST_IDLE;
                end else if (w_out_free && w_emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control, configuration and button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_debounce   <= DEBOUNCE_RESET;
            r_long_press <= LONG_PRESS_RESET;
            r_now        <= '0;
            r_pressed    <= '0;
            r_long_sent  <= '0;
            r_mask       <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_last_edge[i]   <= '0;
                r_press_start[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                if (i_cfg_index == REG_DEBOUNCE) begin
                    r_debounce <= i_cfg_data;
                end else if (i_cfg_index == REG_LONG_PRESS) begin
                    r_long_press <= i_cfg_data;
                end
            end

            // output register: loads a new report or drops a taken one
            r_out_valid <= w_out_load || (r_out_valid && !i_ready);

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_head;
                        r_idx <= '0;
                        r_cnt <= '0;
                        if (i_head.is_tick) begin
                            r_now <= r_now + 1'b1;
                        end
                    end
                end
                ST_EDGE: begin
                    if (w_edge_ok && (!w_edge_report || w_out_free)) begin
                        r_last_edge[w_eb] <= r_now;
                        if (r_cmd.level) begin
                            r_pressed[w_eb]     <= 1'b1;
                            r_press_start[w_eb] <= r_now;
                            r_long_sent[w_eb]   <= 1'b0;
                        end else if (r_pressed[w_eb]) begin
                            r_pressed[w_eb]   <= 1'b0;
                            r_long_sent[w_eb] <= 1'b0;
                        end
                        if (w_edge_report) begin
                            r_out_id    <= r_cmd.button;
                            r_out_kind  <= w_edge_long ? KIND_LONG : KIND_SHORT;
                            r_out_last  <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_mask[r_idx] <= w_scan_hit;
                    r_idx         <= r_idx + 1'b1;
                end
                ST_EMIT: begin
                    if (r_mask != '0 && w_out_free) begin
                        r_out_id           <= BUTTON_W'(w_low);
                        r_out_kind         <= KIND_LONG;
                        r_out_last         <= w_emit_last;
                        r_long_sent[w_low] <= 1'b1;
                        r_mask             <= w_emit_last ? '0 : w_rem;
                        r_cnt              <= r_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_button_id  = r_out_id;
    assign o_press_kind = r_out_kind;
    assign o_last       = r_out_last;

endmodule

/* design/bdpc_checker.sv */
// bdpc_checker: port-level assertions on the press classifier
// depends on bdpc_pkg; bound to button_debounce_press_classifier_core

module bdpc_checker
    import bdpc_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a stalled report beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
        $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("report beat changed while stalled");

    // no report right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("report valid after reset");

    // a short press comes only from a release, which is always alone
    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SHORT) |-> m_axis_tlast)
        else $error("short press report not marked last");

    // reported buttons exist and padding stays zero
    a_button_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[BUTTON_W-1:0]} <
        (BUTTON_W+1)'(BUTTON_COUNT)) &&
        (m_axis_tdata[TDATA_OUT_W-1:BUTTON_W] == '0))
        else $error("report names a button that does not exist");

endmodule

bind button_debounce_press_classifier_core bdpc_checker #(
    .BUTTON_COUNT (BUTTON_COUNT)
) u_bdpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
